/* rtl/bbpp_pkg.sv */
`default_nettype none

package bbpp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int TRI_W     = 3 * DATA_W;
    localparam int LIN_W     = PROD_W + 2;
    localparam int DEN_W     = TRI_W + 4;
    localparam int NUM_W     = TRI_W;
    localparam int DD_W      = PROD_W + FRAC_BITS + 2;
    localparam int T_W       = 5 * DATA_W + FRAC_BITS + 4;
    localparam int GS_W      = T_W + 2;
    localparam int DIV_W     = T_W + 1 + 2 * FRAC_BITS;
    localparam int MUL_W     = 4 * DATA_W;
    localparam int QB        = DATA_W + 1;
    localparam int DIV_ST    = QB + 1;
    localparam int NLANES    = 5;
    localparam int NGRAD     = 4;
    localparam int CFG_W     = 2 * DATA_W;
    localparam int CFG_IDX_W = 3;
    localparam int IN_W      = 4 * DATA_W;
    localparam int OUT_W     = ((NLANES * DATA_W + 2 + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_RATE_GAINS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_AB   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_PQ   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CROSS_AB_AP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CROSS_BQ_PQ = 3'd4;

    localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [DATA_W-1:0] v1;
        logic [DATA_W-1:0] v2;
        logic [DATA_W-1:0] ka;
        logic [DATA_W-1:0] kb;
        logic [DATA_W-1:0] kp;
        logic [DATA_W-1:0] kq;
        logic [DATA_W-1:0] kab;
        logic [DATA_W-1:0] kap;
        logic [DATA_W-1:0] kbq;
        logic [DATA_W-1:0] kpq;
    } cfg_t;

    typedef struct packed {
        logic [DEN_W-1:0]             den;
        logic [NUM_W-1:0]             num;
        logic                         num_neg;
        logic [NGRAD-1:0][PROD_W-1:0] gy;
        logic [NGRAD-1:0][DD_W-1:0]   dd;
    } front_t;

    typedef struct packed {
        logic [QB-1:0] q;
        logic          neg;
        logic          ovf;
    } quo_t;

    // 32 x 64 product as two 32 x 32 partials
    function automatic logic [TRI_W-1:0] mul_32x64(input logic [DATA_W-1:0] x,
                                                   input logic [PROD_W-1:0] y);
        logic [PROD_W-1:0] lo;
        logic [PROD_W-1:0] hi;
        lo = PROD_W'(x) * PROD_W'(y[DATA_W-1:0]);
        hi = PROD_W'(x) * PROD_W'(y[PROD_W-1:DATA_W]);
        return {hi, {DATA_W{1'b0}}} + TRI_W'(lo);
    endfunction

endpackage

`default_nettype wire

/* rtl/bbpp_mul.sv */
`default_nettype none

module bbpp_mul
    import bbpp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [MUL_W-1:0]     a,
    input  wire logic [MUL_W-1:0]     b,
    output logic      [2*MUL_W-1:0]   p
);

    localparam int LIMBS = MUL_W / DATA_W;
    localparam int ROW_W = MUL_W + DATA_W;

    logic [PROD_W-1:0]  pp_reg [LIMBS][LIMBS];
    logic [ROW_W-1:0]   row [LIMBS];
    logic [2*MUL_W-1:0] acc_next;
    logic [2*MUL_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LIMBS; i++)
            begin
                for (int j = 0; j < LIMBS; j++)
                begin
                    pp_reg[i][j] <= PROD_W'(a[i*DATA_W +: DATA_W])
                                    * PROD_W'(b[j*DATA_W +: DATA_W]);
                end
            end
        end
    end

    // even and odd partials of a row do not overlap, so each row is one add
    always_comb
    begin
        for (int i = 0; i < LIMBS; i++)
        begin
            row[i] = ROW_W'({pp_reg[i][2], pp_reg[i][0]})
                     + (ROW_W'({pp_reg[i][3], pp_reg[i][1]}) << DATA_W);
        end
        acc_next = ((2*MUL_W)'(row[0]) + ((2*MUL_W)'(row[1]) << DATA_W))
                   + (((2*MUL_W)'(row[2]) << (2*DATA_W))
                      + ((2*MUL_W)'(row[3]) << (3*DATA_W)));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= acc_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

/* rtl/bbpp_front.sv */
`default_nettype none

module bbpp_front
    import bbpp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              valid_in,
    input  wire logic [DATA_W-1:0] conc_a,
    input  wire logic [DATA_W-1:0] conc_b,
    input  wire logic [DATA_W-1:0] conc_p,
    input  wire logic [DATA_W-1:0] conc_q,
    input  wire cfg_t              cfg,
    output logic                   valid_out,
    output front_t                 res
);

    logic [3:0]        vld_reg;
    logic [DATA_W-1:0] a_reg, b_reg, p_reg, q_reg;

    logic [PROD_W-1:0] la_reg, lb_reg, lp_reg, lq_reg;
    logic [PROD_W-1:0] ab_reg, ap_reg, bq_reg, pq_reg;
    logic [PROD_W-1:0] gy2_reg [NGRAD];
    logic [PROD_W-1:0] e_reg [2*NGRAD];

    logic [LIN_W-1:0]  lin_reg;
    logic [TRI_W-1:0]  tab_reg, tap_reg, tbq_reg, tpq_reg, f_reg, r_reg;
    logic [PROD_W-1:0] gy3_reg [NGRAD];
    logic [DD_W-1:0]   dd3_reg [NGRAD];
    logic [DATA_W-1:0] kd [NGRAD];

    front_t res_reg;
    front_t res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= conc_a;
            b_reg <= conc_b;
            p_reg <= conc_p;
            q_reg <= conc_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            la_reg     <= PROD_W'(cfg.ka) * PROD_W'(a_reg);
            lb_reg     <= PROD_W'(cfg.kb) * PROD_W'(b_reg);
            lp_reg     <= PROD_W'(cfg.kp) * PROD_W'(p_reg);
            lq_reg     <= PROD_W'(cfg.kq) * PROD_W'(q_reg);
            ab_reg     <= PROD_W'(a_reg) * PROD_W'(b_reg);
            ap_reg     <= PROD_W'(a_reg) * PROD_W'(p_reg);
            bq_reg     <= PROD_W'(b_reg) * PROD_W'(q_reg);
            pq_reg     <= PROD_W'(p_reg) * PROD_W'(q_reg);
            gy2_reg[0] <= PROD_W'(cfg.v1) * PROD_W'(b_reg);
            gy2_reg[1] <= PROD_W'(cfg.v1) * PROD_W'(a_reg);
            gy2_reg[2] <= PROD_W'(cfg.v2) * PROD_W'(q_reg);
            gy2_reg[3] <= PROD_W'(cfg.v2) * PROD_W'(p_reg);
            e_reg[0]   <= PROD_W'(cfg.kab) * PROD_W'(b_reg);
            e_reg[1]   <= PROD_W'(cfg.kap) * PROD_W'(p_reg);
            e_reg[2]   <= PROD_W'(cfg.kab) * PROD_W'(a_reg);
            e_reg[3]   <= PROD_W'(cfg.kbq) * PROD_W'(q_reg);
            e_reg[4]   <= PROD_W'(cfg.kap) * PROD_W'(a_reg);
            e_reg[5]   <= PROD_W'(cfg.kpq) * PROD_W'(q_reg);
            e_reg[6]   <= PROD_W'(cfg.kbq) * PROD_W'(b_reg);
            e_reg[7]   <= PROD_W'(cfg.kpq) * PROD_W'(p_reg);
        end
    end

    assign kd[0] = cfg.ka;
    assign kd[1] = cfg.kb;
    assign kd[2] = cfg.kp;
    assign kd[3] = cfg.kq;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lin_reg <= LIN_W'(la_reg) + LIN_W'(lb_reg) + LIN_W'(lp_reg) + LIN_W'(lq_reg);
            tab_reg <= mul_32x64(cfg.kab, ab_reg);
            tap_reg <= mul_32x64(cfg.kap, ap_reg);
            tbq_reg <= mul_32x64(cfg.kbq, bq_reg);
            tpq_reg <= mul_32x64(cfg.kpq, pq_reg);
            f_reg   <= mul_32x64(cfg.v1, ab_reg);
            r_reg   <= mul_32x64(cfg.v2, pq_reg);
            for (int i = 0; i < NGRAD; i++)
            begin
                gy3_reg[i] <= gy2_reg[i];
                dd3_reg[i] <= (DD_W'(kd[i]) << FRAC_BITS) + DD_W'(e_reg[2*i])
                              + DD_W'(e_reg[2*i+1]);
            end
        end
    end

    always_comb
    begin
        res_next.den = (DEN_W'(lin_reg) << FRAC_BITS) + DEN_W'(tab_reg) + DEN_W'(tap_reg)
                       + DEN_W'(tbq_reg) + DEN_W'(tpq_reg);
        res_next.num_neg = f_reg < r_reg;
        res_next.num     = res_next.num_neg ? (r_reg - f_reg) : (f_reg - r_reg);
        for (int i = 0; i < NGRAD; i++)
        begin
            res_next.gy[i] = gy3_reg[i];
            res_next.dd[i] = dd3_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res       = res_reg;
    assign valid_out = vld_reg[3];

endmodule

`default_nettype wire

/* rtl/bbpp_div.sv */
`default_nettype none

module bbpp_div
    import bbpp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [DIV_W-1:0] num_in,
    input  wire logic [DIV_W-1:0] den_in,
    input  wire logic             neg_in,
    output quo_t                  quo
);

    localparam int CW = DIV_W + QB;

    logic [DIV_W-1:0] r_reg   [DIV_ST];
    logic [DIV_W-1:0] d_reg   [DIV_ST];
    logic [QB-1:0]    q_reg   [DIV_ST];
    logic             neg_reg [DIV_ST];
    logic             ovf_reg [DIV_ST];

    // quotient of 2^QB or more saturates regardless of the low bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= num_in;
            d_reg[0]   <= den_in;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg_in;
            ovf_reg[0] <= {{QB{1'b0}}, num_in} >= {den_in, {QB{1'b0}}};
        end
    end

    for (genvar j = 1; j < DIV_ST; j++)
    begin : g_step
        logic [CW-1:0] sh;
        logic [CW-1:0] rem_ext;
        logic [CW-1:0] diff;
        logic          ge;

        always_comb
        begin
            sh      = {{QB{1'b0}}, d_reg[j-1]} << (QB - j);
            rem_ext = {{QB{1'b0}}, r_reg[j-1]};
            ge      = rem_ext >= sh;
            diff    = rem_ext - sh;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[j]   <= ge ? diff[DIV_W-1:0] : r_reg[j-1];
                d_reg[j]   <= d_reg[j-1];
                q_reg[j]   <= q_reg[j-1] | (QB'(ge) << (QB - j));
                neg_reg[j] <= neg_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end
    end

    assign quo.q   = q_reg[DIV_ST-1];
    assign quo.neg = neg_reg[DIV_ST-1];
    assign quo.ovf = ovf_reg[DIV_ST-1];

endmodule

`default_nettype wire

/* rtl/bibi_ping_pong_rate_gradient.sv */
`default_nettype none

// Bi-Bi ping-pong rate law with its four partial derivatives, fixed point.
// Input stream (s_*): one transfer carries the concentrations A, B, P, Q.
// Output stream (m_*): one transfer per input carries the rate, the four
// gradients and the zero-denominator and saturation flags.
// Coefficients are loaded through cfg_we / cfg_index / cfg_data; the user
// must load them only while the block is idle, as the block itself does not
// enforce this. A write to an unused index is dropped. From input transfer to
// output valid, 4 stages build numerator and denominator (the first loads on
// the transfer edge), 2 stages for the wide limb multipliers, 1 forms the
// quotient operands and 34 run five restoring divider lanes side by side, then
// a merge stage saturates into the output register.
// Throughput is one transfer per cycle, set by the fully pipelined lanes.
// When m_tready is low and the output register is full, the whole pipeline
// holds and s_tready drops. Reset clears the coefficients to zero and
// empties the pipeline.

module bibi_ping_pong_rate_gradient
    import bbpp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_W-1:0]      s_tdata,   // conc_a, conc_b, conc_p, conc_q
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [OUT_W-1:0]     m_tdata,   // rate, grad_a, grad_b, grad_p,
                                                 // grad_q, zero_denominator,
                                                 // saturated, zero pad
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0] gains_reg, lab_reg, lpq_reg, xabp_reg, xbqpq_reg;
    cfg_t             cfg;

    logic   adv;
    logic   f_valid;
    front_t f_res;

    logic [2*MUL_W-1:0] gy_prod [NGRAD];
    logic [2*MUL_W-1:0] dd_prod [NGRAD];
    logic [2*MUL_W-1:0] den2_prod;

    logic [1:0]       mv_reg;
    logic [DEN_W-1:0] mden_reg [2];
    logic [NUM_W-1:0] mnum_reg [2];
    logic             mneg_reg [2];

    logic             pv_reg;
    logic             pzero_reg;
    logic [DIV_W-1:0] px_reg   [NLANES];
    logic [DIV_W-1:0] pd_reg   [NLANES];
    logic             pneg_reg [NLANES];
    logic [DIV_W-1:0] px_next  [NLANES];
    logic [DIV_W-1:0] pd_next  [NLANES];
    logic             pneg_next[NLANES];

    logic [DIV_ST-1:0] vld_d_reg;
    logic [DIV_ST-1:0] zero_d_reg;
    quo_t              quo [NLANES];

    logic [DATA_W-1:0] val  [NLANES];
    logic [NLANES-1:0] lsat;
    logic [OUT_W-1:0]  out_next;
    logic [OUT_W-1:0]  out_reg;
    logic              out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg <= '0;
            lab_reg   <= '0;
            lpq_reg   <= '0;
            xabp_reg  <= '0;
            xbqpq_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RATE_GAINS:  gains_reg <= cfg_data;
                REG_LINEAR_AB:   lab_reg   <= cfg_data;
                REG_LINEAR_PQ:   lpq_reg   <= cfg_data;
                REG_CROSS_AB_AP: xabp_reg  <= cfg_data;
                REG_CROSS_BQ_PQ: xbqpq_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign cfg.v1  = gains_reg[CFG_W-1:DATA_W];
    assign cfg.v2  = gains_reg[DATA_W-1:0];
    assign cfg.ka  = lab_reg[CFG_W-1:DATA_W];
    assign cfg.kb  = lab_reg[DATA_W-1:0];
    assign cfg.kp  = lpq_reg[CFG_W-1:DATA_W];
    assign cfg.kq  = lpq_reg[DATA_W-1:0];
    assign cfg.kab = xabp_reg[CFG_W-1:DATA_W];
    assign cfg.kap = xabp_reg[DATA_W-1:0];
    assign cfg.kbq = xbqpq_reg[CFG_W-1:DATA_W];
    assign cfg.kpq = xbqpq_reg[DATA_W-1:0];

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    bbpp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .valid_in  (s_tvalid),
        .conc_a    (s_tdata[DATA_W-1:0]),
        .conc_b    (s_tdata[2*DATA_W-1:DATA_W]),
        .conc_p    (s_tdata[3*DATA_W-1:2*DATA_W]),
        .conc_q    (s_tdata[4*DATA_W-1:3*DATA_W]),
        .cfg       (cfg),
        .valid_out (f_valid),
        .res       (f_res)
    );

    for (genvar i = 0; i < NGRAD; i++)
    begin : g_mul
        bbpp_mul u_mul_gy (
            .clk (clk),
            .en  (adv),
            .a   (MUL_W'(f_res.den)),
            .b   (MUL_W'(f_res.gy[i])),
            .p   (gy_prod[i])
        );

        bbpp_mul u_mul_dd (
            .clk (clk),
            .en  (adv),
            .a   (MUL_W'(f_res.num)),
            .b   (MUL_W'(f_res.dd[i])),
            .p   (dd_prod[i])
        );
    end

    bbpp_mul u_mul_den2 (
        .clk (clk),
        .en  (adv),
        .a   (MUL_W'(f_res.den)),
        .b   (MUL_W'(f_res.den)),
        .p   (den2_prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= '0;
        end
        else if (adv)
        begin
            mv_reg <= {mv_reg[0], f_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mden_reg[0] <= f_res.den;
            mnum_reg[0] <= f_res.num;
            mneg_reg[0] <= f_res.num_neg;
            mden_reg[1] <= mden_reg[0];
            mnum_reg[1] <= mnum_reg[0];
            mneg_reg[1] <= mneg_reg[0];
        end
    end

    // lane 0 is the rate, lanes 1..4 the gradients by A, B, P, Q
    always_comb
    begin
        px_next[0]   = DIV_W'({mnum_reg[1], {FRAC_BITS{1'b0}}});
        pd_next[0]   = DIV_W'(mden_reg[1]);
        pneg_next[0] = mneg_reg[1];
    end

    for (genvar i = 0; i < NGRAD; i++)
    begin : g_prep
        logic signed [GS_W-1:0] t1;
        logic signed [GS_W-1:0] t2;
        logic signed [GS_W-1:0] s;
        logic        [GS_W-2:0] mag;

        always_comb
        begin
            t1  = GS_W'(gy_prod[i][T_W-1:0]);
            t2  = GS_W'(dd_prod[i][T_W-1:0]);
            s   = ((i >= 2) ? -t1 : t1) + (mneg_reg[1] ? t2 : -t2);
            mag = s[GS_W-1] ? (GS_W-1)'(-s) : s[GS_W-2:0];
            px_next[i+1]   = {mag, {(2*FRAC_BITS){1'b0}}};
            pd_next[i+1]   = DIV_W'(den2_prod[2*DEN_W-1:0]);
            pneg_next[i+1] = s[GS_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else if (adv)
        begin
            pv_reg <= mv_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pzero_reg <= mden_reg[1] == '0;
            for (int i = 0; i < NLANES; i++)
            begin
                px_reg[i]   <= px_next[i];
                pd_reg[i]   <= pd_next[i];
                pneg_reg[i] <= pneg_next[i];
            end
        end
    end

    for (genvar i = 0; i < NLANES; i++)
    begin : g_lane
        bbpp_div u_div (
            .clk    (clk),
            .en     (adv),
            .num_in (px_reg[i]),
            .den_in (pd_reg[i]),
            .neg_in (pneg_reg[i]),
            .quo    (quo[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_d_reg <= '0;
        end
        else if (adv)
        begin
            vld_d_reg <= {vld_d_reg[DIV_ST-2:0], pv_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zero_d_reg <= {zero_d_reg[DIV_ST-2:0], pzero_reg};
        end
    end

    // merge: saturate each lane, then force zero on a zero denominator
    always_comb
    begin
        for (int i = 0; i < NLANES; i++)
        begin
            lsat[i] = quo[i].ovf
                      || (!quo[i].neg && quo[i].q > QB'(SAT_POS))
                      || (quo[i].neg && quo[i].q > QB'(SAT_NEG));
            if (zero_d_reg[DIV_ST-1])
            begin
                val[i] = '0;
            end
            else if (lsat[i])
            begin
                val[i] = quo[i].neg ? SAT_NEG : SAT_POS;
            end
            else
            begin
                val[i] = quo[i].neg ? (DATA_W'(0) - quo[i].q[DATA_W-1:0])
                                    : quo[i].q[DATA_W-1:0];
            end
        end
        out_next = OUT_W'({!zero_d_reg[DIV_ST-1] && (lsat != '0), zero_d_reg[DIV_ST-1],
                           val[4], val[3], val[2], val[1], val[0]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vld_d_reg[DIV_ST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

`default_nettype wire

/* tb/sv/bbpp_checker.sv */
`timescale 1ns / 100ps

module bbpp_checker
    import bbpp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [IN_W-1:0]      s_tdata,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [OUT_W-1:0]     m_tdata,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output int                        fail_count,
    output int                        rates_pending
);

    typedef struct packed {
        logic [DATA_W-1:0] rate;
        logic [DATA_W-1:0] grad_a;
        logic [DATA_W-1:0] grad_b;
        logic [DATA_W-1:0] grad_p;
        logic [DATA_W-1:0] grad_q;
        logic              zero_den;
        logic              sat;
    } rate_result_t;

    logic [CFG_W-1:0] gains, lin_ab, lin_pq, x_ab_ap, x_bq_pq;
    rate_result_t     expected_rates[$];

    function automatic logic [DATA_W-1:0] clip(logic [255:0] mag, bit neg, inout bit sat);
        if (!neg && mag > 256'h7FFF_FFFF)
        begin
            sat = 1'b1;
            return SAT_POS;
        end
        if (neg && mag > 256'h8000_0000)
        begin
            sat = 1'b1;
            return SAT_NEG;
        end
        return neg ? -mag[DATA_W-1:0] : mag[DATA_W-1:0];
    endfunction

    // ((+/-) D*g*y - N*dD) << 2F, over D^2
    function automatic logic [DATA_W-1:0] gradient(logic [255:0] den, logic [255:0] den2,
                                                   logic signed [263:0] num, bit neg,
                                                   logic [255:0] g, logic [255:0] y,
                                                   logic [255:0] dd, inout bit sat);
        logic signed [263:0] t1;
        logic signed [263:0] dds;
        logic signed [263:0] s;
        logic [263:0]        mag;
        t1  = 264'(den) * 264'(g) * 264'(y);
        dds = 264'(dd);
        if (neg)
            t1 = -t1;
        s   = (t1 - num * dds) <<< (2 * FRAC_BITS);
        mag = (s < 0) ? -s : s;
        return clip(mag[255:0] / den2, s < 0, sat);
    endfunction

    function automatic rate_result_t predict_rate(logic [IN_W-1:0] conc);
        logic [255:0]        a, b, p, q, v1, v2, ka, kb, kp, kq, kab, kap, kbq, kpq;
        logic [255:0]        den, den2, nmag;
        logic signed [263:0] fwd, bwd, num;
        rate_result_t        res;
        bit                  sat;
        a   = 256'(conc[31:0]);
        b   = 256'(conc[63:32]);
        p   = 256'(conc[95:64]);
        q   = 256'(conc[127:96]);
        v1  = 256'(gains[63:32]);   v2  = 256'(gains[31:0]);
        ka  = 256'(lin_ab[63:32]);  kb  = 256'(lin_ab[31:0]);
        kp  = 256'(lin_pq[63:32]);  kq  = 256'(lin_pq[31:0]);
        kab = 256'(x_ab_ap[63:32]); kap = 256'(x_ab_ap[31:0]);
        kbq = 256'(x_bq_pq[63:32]); kpq = 256'(x_bq_pq[31:0]);
        sat = 1'b0;
        res = '0;
        den = ((ka * a + kb * b + kp * p + kq * q) << FRAC_BITS)
              + kab * a * b + kap * a * p + kbq * b * q + kpq * p * q;
        if (den == 0)
        begin
            res.zero_den = 1'b1;
            return res;
        end
        fwd  = 264'(v1 * a * b);
        bwd  = 264'(v2 * p * q);
        num  = fwd - bwd;
        nmag = 256'((num < 0) ? -num : num);
        if (nmag != 0)
            res.rate = clip((nmag << FRAC_BITS) / den, num < 0, sat);
        den2 = den * den;
        res.grad_a = gradient(den, den2, num, 1'b0, v1, b,
                              (ka << FRAC_BITS) + kab * b + kap * p, sat);
        res.grad_b = gradient(den, den2, num, 1'b0, v1, a,
                              (kb << FRAC_BITS) + kab * a + kbq * q, sat);
        res.grad_p = gradient(den, den2, num, 1'b1, v2, q,
                              (kp << FRAC_BITS) + kap * a + kpq * q, sat);
        res.grad_q = gradient(den, den2, num, 1'b1, v2, p,
                              (kq << FRAC_BITS) + kbq * b + kpq * p, sat);
        res.sat = sat;
        return res;
    endfunction

    function automatic rate_result_t unpack_result(logic [OUT_W-1:0] d);
        rate_result_t r;
        r.rate     = d[31:0];
        r.grad_a   = d[63:32];
        r.grad_b   = d[95:64];
        r.grad_p   = d[127:96];
        r.grad_q   = d[159:128];
        r.zero_den = d[160];
        r.sat      = d[161];
        return r;
    endfunction

    task automatic compare_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] got);
        if (exp_v !== got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rate_result_t got, exp_r;
        if (!rst_n)
        begin
            gains   <= '0;
            lin_ab  <= '0;
            lin_pq  <= '0;
            x_ab_ap <= '0;
            x_bq_pq <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RATE_GAINS:  gains   <= cfg_data;
                    REG_LINEAR_AB:   lin_ab  <= cfg_data;
                    REG_LINEAR_PQ:   lin_pq  <= cfg_data;
                    REG_CROSS_AB_AP: x_ab_ap <= cfg_data;
                    REG_CROSS_BQ_PQ: x_bq_pq <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_rates.insert(expected_rates.size(), predict_rate(s_tdata));
            if (m_tvalid && m_tready)
            begin
                got = unpack_result(m_tdata);
                if (expected_rates.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result transfer, expected none, got %h",
                             $time, m_tdata);
                end
                else
                begin
                    exp_r = expected_rates.pop_front();
                    compare_field("rate", exp_r.rate, got.rate);
                    compare_field("grad_a", exp_r.grad_a, got.grad_a);
                    compare_field("grad_b", exp_r.grad_b, got.grad_b);
                    compare_field("grad_p", exp_r.grad_p, got.grad_p);
                    compare_field("grad_q", exp_r.grad_q, got.grad_q);
                    compare_field("zero_denominator", DATA_W'(exp_r.zero_den),
                                  DATA_W'(got.zero_den));
                    compare_field("saturated", DATA_W'(exp_r.sat), DATA_W'(got.sat));
                end
            end
        end
        rates_pending <= expected_rates.size();
    end

    initial
    begin
        fail_count    = 0;
        rates_pending = 0;
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import bbpp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int RANDOM_PER_PHASE = 175;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_count;
    int                   rates_pending;
    int                   send_idle_pct;
    int                   recv_stall_pct;
    int                   cycles;

    bibi_ping_pong_rate_gradient dut (.*);

    bbpp_checker chk (.*);

    always #2 clk = ~clk;

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] pick_word(int mode);
        case (mode)
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 32'h3FFFF);
            3: return $urandom_range(0, 32'h1FF) << 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // style: 0 zero, 1 all ones, 2 small, 3 integer-ish, 4 full random, 5 mixed halves
    task automatic load_coefficients(int style);
        logic [CFG_IDX_W-1:0] idx;
        for (int i = 0; i < 5; i++)
        begin
            idx = CFG_IDX_W'(i);
            if (style == 5)
                write_reg(idx, {pick_word($urandom_range(0, 4)), pick_word($urandom_range(0, 4))});
            else
                write_reg(idx, {pick_word(style), pick_word(style)});
        end
        write_reg(REG_UNUSED + CFG_IDX_W'($urandom_range(0, 2)), '1);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (rates_pending == 0);
        repeat (60) @(posedge clk);
    endtask

    task automatic send_conc(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                             logic [DATA_W-1:0] p, logic [DATA_W-1:0] q);
        s_tvalid <= 1'b1;
        s_tdata  <= {q, p, b, a};
        do
            @(posedge clk);
        while (!s_tready);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_random;
        send_conc(pick_word($urandom_range(0, 5)), pick_word($urandom_range(0, 5)),
                  pick_word($urandom_range(0, 5)), pick_word($urandom_range(0, 5)));
    endtask

    task automatic set_idling(int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
        endcase
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero coefficients after reset: zero denominator everywhere
        send_conc('0, '0, '0, '0);
        send_conc('1, '1, '1, '1);
        drain();

        write_reg(REG_RATE_GAINS,  {32'h0001_0000, 32'h0000_8000});
        write_reg(REG_LINEAR_AB,   {32'h0001_0000, 32'h0002_0000});
        write_reg(REG_LINEAR_PQ,   {32'h0000_4000, 32'h0000_0000});
        write_reg(REG_CROSS_AB_AP, {32'h0000_0000, 32'h0001_0000});
        write_reg(REG_CROSS_BQ_PQ, {32'h0003_0000, 32'h0000_0100});
        send_conc('0, '0, '0, '0);
        send_conc(32'h0001_0000, '0, 32'h0002_0000, '0);
        send_conc(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_conc(32'h0002_0000, 32'h0001_0000, 32'h0004_0000, 32'h0001_0000);
        send_conc('1, '1, '0, '0);
        send_conc('0, '0, '1, '1);
        send_conc('1, '1, '1, '1);
        send_conc(32'h0000_0001, '1, 32'h0000_0001, 32'h8000_0000);
        send_conc(32'h0000_0001, 32'h0000_0001, '0, '0);
        drain();

        // huge gains over a tiny denominator: saturation both ways
        write_reg(REG_RATE_GAINS,  '1);
        write_reg(REG_LINEAR_AB,   {32'h0000_0001, 32'h0000_0000});
        write_reg(REG_LINEAR_PQ,   '0);
        write_reg(REG_CROSS_AB_AP, '0);
        write_reg(REG_CROSS_BQ_PQ, '0);
        send_conc(32'h0000_0001, '1, '0, '0);
        send_conc(32'h0000_0001, '0, '1, '1);
        send_conc('0, '1, '1, '1);
        send_conc('1, '1, '1, '1);
        send_conc(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            load_coefficients(phase < 6 ? phase : 5);
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                set_idling((i < RANDOM_PER_PHASE / 2) ? phase : phase + 1);
                if (phase == 3 && i == RANDOM_PER_PHASE / 2)
                begin
                    s_tvalid <= 1'b0;
                    @(posedge clk);
                    wait (rates_pending == 0);
                end
                send_random();
            end
            drain();
        end

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
